// ===== rtl/bop_pkg.sv =====
// bop_pkg: shared widths, register indexes and the configuration struct
// of the balanced order id pool. No dependencies.

package bop_pkg;

    // field widths
    localparam int ID_W      = 17;
    localparam int FIRST_W   = 16;
    localparam int COUNT_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ID       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 2'd2;

    // reset values of the registers
    localparam logic [FIRST_W-1:0] RST_FIRST_ID       = 16'd0;
    localparam logic [COUNT_W-1:0] RST_POOL_COUNT     = 11'd1024;
    localparam logic [COUNT_W-1:0] RST_START_POSITION = 11'd0;

    // register values and change strobe towards the back end
    typedef struct packed {
        logic [FIRST_W-1:0] first_id;
        logic [COUNT_W-1:0] pool_count;
        logic [COUNT_W-1:0] start_position;
        logic               changed;
    } t_cfg;

endpackage

// ===== rtl/bop_ram.sv =====
// bop_ram: generic simple dual port RAM, one write and one registered read port.
// No dependencies.

module bop_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bop_front.sv =====
// bop_front: accepts take requests, drops the null ones and queues the rest
// as tokens for the back end. Depends on nothing.

module bop_front (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  logic i_take_request,
    output logic o_tok_avail,
    input  logic i_tok_pop
);

    localparam int DEPTH = 2;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          take_in;
    logic          tok_out;

    // a transfer carrying a real request becomes a token
    assign take_in = push && !full && i_take_request;
    assign tok_out = i_tok_pop && o_tok_avail;

    // token count
    always_comb begin
        n_count = r_count;
        if (take_in && !tok_out) begin
            n_count = r_count + 1'b1;
        end else if (!take_in && tok_out) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign full        = (r_count == CW'(DEPTH));
    assign o_tok_avail = (r_count != '0);

endmodule

// ===== rtl/bop_back.sv =====
// bop_back: builds the level order store from the interval queue and serves
// takes into the result register. Depends on bop_pkg and bop_ram.

module bop_back #(
    parameter int POOL_SIZE = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bop_pkg::t_cfg               i_cfg,
    input  logic                        i_tok_avail,
    output logic                        o_tok_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [bop_pkg::ID_W-1:0]    o_card_id,
    output logic                        o_exhausted
);

    import bop_pkg::*;

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int QW = 2 * ID_W;
    localparam int PW = COUNT_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_MID   = 3'd3;
    localparam logic [2:0] S_RIGHT = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]         r_state, n_state;
    logic               r_store_valid, n_store_valid;
    logic [COUNT_W-1:0] r_takes_done, n_takes_done;
    logic [COUNT_W-1:0] r_head, n_head;
    logic [COUNT_W-1:0] r_tail, n_tail;
    logic [COUNT_W-1:0] r_fill, n_fill;
    logic [ID_W-1:0]    r_mid, n_mid;
    logic [ID_W-1:0]    r_hi, n_hi;
    logic               r_out_valid, n_out_valid;
    logic [ID_W-1:0]    r_out_card, n_out_card;
    logic               r_out_exh, n_out_exh;

    logic               q_we, q_re;
    logic [AW-1:0]      q_waddr;
    logic [QW-1:0]      q_wdata, q_rdata;
    logic               s_we, s_re;
    logic [AW-1:0]      s_waddr;
    logic [ID_W-1:0]    s_wdata, s_rdata;

    logic [COUNT_W-1:0] eff_count;
    logic [PW-1:0]      pos;
    logic               pos_hit;
    logic [ID_W-1:0]    rd_lo, rd_hi, mid;
    logic [ID_W:0]      mid_sum;
    logic               out_free, out_xfer;
    logic               right_push;
    logic [COUNT_W-1:0] tail_after;

    // interval queue, low and high bound side by side
    bop_ram #(.WIDTH(QW), .DEPTH(POOL_SIZE)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (AW'(r_head)),
        .o_rdata (q_rdata)
    );

    // level order id store
    bop_ram #(.WIDTH(ID_W), .DEPTH(POOL_SIZE)) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (AW'(pos)),
        .o_rdata (s_rdata)
    );

    // pool size clamp and take position
    assign eff_count = (ID_W'(i_cfg.pool_count) > ID_W'(POOL_SIZE)) ?
                       COUNT_W'(POOL_SIZE) : i_cfg.pool_count;
    assign pos       = PW'(i_cfg.start_position) + PW'(r_takes_done);
    assign pos_hit   = (pos < PW'(eff_count));

    // floor midpoint of the popped interval
    assign rd_lo   = q_rdata[QW-1:ID_W];
    assign rd_hi   = q_rdata[ID_W-1:0];
    assign mid_sum = (ID_W+1)'(rd_lo) + (ID_W+1)'(rd_hi);
    assign mid     = mid_sum[ID_W:1];

    assign out_xfer   = pop && r_out_valid;
    assign out_free   = !r_out_valid || out_xfer;
    assign right_push = (r_mid < r_hi);
    assign tail_after = right_push ? (r_tail + 1'b1) : r_tail;

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_store_valid = r_store_valid;
        n_takes_done  = r_takes_done;
        n_head        = r_head;
        n_tail        = r_tail;
        n_fill        = r_fill;
        n_mid         = r_mid;
        n_hi          = r_hi;
        n_out_valid   = r_out_valid;
        n_out_card    = r_out_card;
        n_out_exh     = r_out_exh;
        o_tok_pop     = 1'b0;
        q_we          = 1'b0;
        q_waddr       = AW'(r_tail);
        q_wdata       = {rd_lo, mid - 1'b1};
        q_re          = 1'b0;
        s_we          = 1'b0;
        s_waddr       = AW'(r_fill);
        s_wdata       = mid;
        s_re          = 1'b0;

        if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_tok_avail && out_free) begin
                    if (!r_store_valid) begin
                        n_state = S_INIT;
                    end else if (pos_hit) begin
                        s_re         = 1'b1;
                        o_tok_pop    = 1'b1;
                        n_takes_done = r_takes_done + 1'b1;
                        n_state      = S_OUT;
                    end else begin
                        o_tok_pop   = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_card  = '0;
                        n_out_exh   = 1'b1;
                    end
                end
            end
            S_INIT: begin
                if (eff_count == '0) begin
                    n_store_valid = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    q_we    = 1'b1;
                    q_waddr = '0;
                    q_wdata = {ID_W'(i_cfg.first_id),
                               ID_W'(i_cfg.first_id) + ID_W'(eff_count) - 1'b1};
                    n_head  = '0;
                    n_tail  = COUNT_W'(1);
                    n_fill  = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                q_re    = 1'b1;
                n_state = S_MID;
            end
            S_MID: begin
                // emit midpoint, push the left part
                s_we   = 1'b1;
                n_fill = r_fill + 1'b1;
                n_head = r_head + 1'b1;
                if (mid > rd_lo) begin
                    q_we   = 1'b1;
                    n_tail = r_tail + 1'b1;
                end
                n_mid   = mid;
                n_hi    = rd_hi;
                n_state = S_RIGHT;
            end
            S_RIGHT: begin
                // push the right part, stop when full or queue drained
                q_wdata = {r_mid + 1'b1, r_hi};
                if (right_push) begin
                    q_we   = 1'b1;
                    n_tail = tail_after;
                end
                if ((r_fill >= eff_count) || (tail_after == r_head)) begin
                    n_store_valid = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_OUT: begin
                n_out_valid = 1'b1;
                n_out_card  = s_rdata;
                n_out_exh   = 1'b0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a register write forces a rebuild
        if (i_cfg.changed) begin
            n_store_valid = 1'b0;
            n_takes_done  = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_store_valid <= 1'b0;
            r_takes_done  <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_fill        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_store_valid <= n_store_valid;
            r_takes_done  <= n_takes_done;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_fill        <= n_fill;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mid      <= n_mid;
        r_hi       <= n_hi;
        r_out_card <= n_out_card;
        r_out_exh  <= n_out_exh;
    end

    assign empty       = !r_out_valid;
    assign o_card_id   = r_out_card;
    assign o_exhausted = r_out_exh;

    // the queue is never read empty during a build
    a_queue_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_head < r_tail))
        else $error("interval queue read while empty");

    // a store read result never lands on an occupied result register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !r_out_valid)
        else $error("result register overwritten");

    // a register write clears the build and the take count
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.changed |=> (!r_store_valid && (r_takes_done == '0)))
        else $error("config write did not clear pool state");

    // take count only moves on a served take or a register write
    a_takes_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cfg.changed && !s_re) |=> $stable(r_takes_done))
        else $error("take count moved without a take");

endmodule

// ===== rtl/balanced_order_id_pool_top.sv =====
// balanced_order_id_pool_top: top level, configuration registers and the
// front and back ends. Depends on bop_pkg, bop_front, bop_back and bop_ram.
//
// Usage
//   Requests: drive push with i_take_request; a transfer happens when push
//   is high and full is low. A request with i_take_request low is dropped
//   and gives no result. Up to two requests wait ahead of the back end.
//   Results: while empty is low, o_card_id and o_exhausted hold the oldest
//   result; pop takes it. A stalled result holds and the request queue keeps
//   filling until full rises.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 first_id, 1 pool_count, 2 start_position); any listed
//   register write marks the pool for rebuild and zeroes the take count.
//   Timing: with the pool built a take passes the token queue, the registered
//   read of the id store and the result register; no new take starts until
//   the last one is in the result register. An exhausted take needs no read.
//   The first take after reset or a register write first rebuilds the pool,
//   each id in turn through the interval queue read, midpoint write and right
//   part push.
//   Reset: i_rst_n is synchronous and active low; registers return to
//   first_id 0, pool_count 1024, start_position 0 and the pool needs a build.

module balanced_order_id_pool_top #(
    parameter int POOL_SIZE = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_take_request,
    output logic                            empty,
    input  logic                            pop,
    output logic [bop_pkg::ID_W-1:0]        o_card_id,
    output logic                            o_exhausted,
    input  logic                            i_cfg_we,
    input  logic [bop_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bop_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    import bop_pkg::*;

    logic [FIRST_W-1:0] r_first_id;
    logic [COUNT_W-1:0] r_pool_count;
    logic [COUNT_W-1:0] r_start_position;
    t_cfg               cfg;
    logic               tok_avail;
    logic               tok_pop;
    logic               cfg_hit;

    // register file
    always_comb begin
        case (i_cfg_index)
            CFG_FIRST_ID, CFG_POOL_COUNT, CFG_START_POSITION: cfg_hit = 1'b1;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_id       <= RST_FIRST_ID;
            r_pool_count     <= RST_POOL_COUNT;
            r_start_position <= RST_START_POSITION;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_ID:       r_first_id       <= i_cfg_data[FIRST_W-1:0];
                CFG_POOL_COUNT:     r_pool_count     <= i_cfg_data[COUNT_W-1:0];
                CFG_START_POSITION: r_start_position <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.first_id       = r_first_id;
    assign cfg.pool_count     = r_pool_count;
    assign cfg.start_position = r_start_position;
    assign cfg.changed        = i_cfg_we && cfg_hit;

    // request side
    bop_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_take_request (i_take_request),
        .o_tok_avail    (tok_avail),
        .i_tok_pop      (tok_pop)
    );

    // build and take side
    bop_back #(.POOL_SIZE(POOL_SIZE)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_tok_avail (tok_avail),
        .o_tok_pop   (tok_pop),
        .empty       (empty),
        .pop         (pop),
        .o_card_id   (o_card_id),
        .o_exhausted (o_exhausted)
    );

endmodule
